/* hdl/edge_run_ratio_pattern_scanner_top_defines.svh */
// Assertion macros for the edge-run ratio pattern scanner.
// Used by the top level; expects clk and rst_n in scope.
`ifndef EDGE_RUN_RATIO_PATTERN_SCANNER_TOP_DEFINES_SVH
`define EDGE_RUN_RATIO_PATTERN_SCANNER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ERPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ERPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/erps_pkg.sv */
// Shared constants and controller/datapath interface types for the
// edge-run ratio pattern scanner. No dependencies.
package erps_pkg;

  localparam int LINE_LENGTH = 4096;
  localparam int WIN_DEPTH   = 10;
  localparam int NUM_RATIO   = 8;

  localparam int VAL_W   = 8;
  localparam int POS_W   = 12;
  localparam int LINE_W  = 12;
  localparam int GAP_W   = 13;
  localparam int HIT_W   = 15;
  localparam int LIM_W   = 7;
  localparam int PAT_W   = 32;
  localparam int FILL_W  = 4;
  localparam int IDX_W   = 3;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 32;
  localparam int IN_DW   = 32;
  localparam int OUT_DW  = 32;

  localparam logic [VAL_W-1:0] THR_RST = 8'd200;
  localparam logic [LIM_W-1:0] LIM_RST = 7'd40;
  localparam logic [PAT_W-1:0] PAT_RST = 32'h3112_2326;

  localparam logic [CFG_AW-1:0] CFG_EDGE_THRESHOLD = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_ERROR_LIMIT    = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_RATIO_PATTERN  = 2'd2;

  typedef struct packed {
    logic             accept;
    logic             setup;
    logic             issue;
    logic [IDX_W-1:0] idx;
    logic             rev;
    logic             load_out;
  } erps_cmd_t;

  typedef struct packed {
    logic full;
    logic ok;
  } erps_stat_t;

endpackage

/* hdl/erps_ratio.sv */
// Shared ratio-test unit: two-stage pipeline, one ratio per cycle.
// Depends on erps_pkg.
module erps_ratio (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              setup,
  input  logic signed [erps_pkg::GAP_W-1:0] base_in,
  input  logic        [erps_pkg::LIM_W-1:0] lim,
  input  logic                              issue,
  input  logic        [3:0]                 ratio,
  input  logic signed [erps_pkg::GAP_W-1:0] gap,
  output logic                              ok
);

  logic signed [12:0] base_r;
  logic        [20:0] lim1b_r;
  logic signed [16:0] prod_r;
  logic        [24:0] rhs_r;
  logic signed [12:0] p_r;
  logic               v1_r;
  logic               ok_r;

  logic        [12:0] babs;
  logic        [7:0]  lim1;
  logic        [20:0] lim1b_nxt;
  logic signed [16:0] prod_nxt;
  logic        [24:0] rhs_nxt;
  logic        [17:0] diff;
  logic        [17:0] dabs;
  logic        [24:0] d100;
  logic               pass;

  assign babs      = base_in[12] ? 13'(-base_in) : 13'(base_in);
  assign lim1      = {1'b0, lim} + 8'd1;
  assign lim1b_nxt = {13'b0, lim1} * {8'b0, babs};

  assign prod_nxt = $signed({13'b0, ratio}) * $signed({{4{base_r[12]}}, base_r});
  assign rhs_nxt  = {21'b0, ratio} * {4'b0, lim1b_r};

  assign diff = {prod_r[16], prod_r} - {{5{p_r[12]}}, p_r};
  assign dabs = diff[17] ? 18'(-diff) : diff;
  assign d100 = {7'b0, dabs} * 25'd100;
  assign pass = d100 < rhs_r;

  always_ff @(posedge clk) begin
    if (setup) begin
      base_r  <= base_in;
      lim1b_r <= lim1b_nxt;
    end
    prod_r <= prod_nxt;
    rhs_r  <= rhs_nxt;
    p_r    <= gap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      ok_r <= 1'b0;
    end else begin
      v1_r <= issue;
      if (setup) begin
        ok_r <= 1'b1;
      end else if (v1_r) begin
        ok_r <= ok_r & pass;
      end
    end
  end

  assign ok = ok_r;

endmodule

/* hdl/erps_dp.sv */
// Datapath: config registers, gap/position windows, base and hit arithmetic,
// output payload register. Depends on erps_pkg and erps_ratio.
module erps_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [erps_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [erps_pkg::CFG_DW-1:0]      cfg_wdata,
  input  logic [erps_pkg::IN_DW-1:0]       in_tdata,
  input  erps_pkg::erps_cmd_t              cmd,
  output erps_pkg::erps_stat_t             st,
  output logic [erps_pkg::OUT_DW-1:0]      out_tdata,
  output logic                             out_tuser
);

  logic [erps_pkg::VAL_W-1:0] thr_r;
  logic [erps_pkg::LIM_W-1:0] lim_r;
  logic [erps_pkg::PAT_W-1:0] pat_r;

  logic signed [erps_pkg::GAP_W-1:0] gap_win_r  [erps_pkg::WIN_DEPTH];
  logic        [erps_pkg::POS_W-1:0] epos_win_r [erps_pkg::WIN_DEPTH];
  logic signed [erps_pkg::GAP_W-1:0] prev_edge_r;
  logic signed [erps_pkg::GAP_W-1:0] prev_old_r;
  logic        [erps_pkg::FILL_W-1:0] fill_r;
  logic        [erps_pkg::LINE_W-1:0] line_r;

  logic                               side_r;
  logic        [erps_pkg::LINE_W-1:0] line_out_r;
  logic        [erps_pkg::HIT_W-1:0]  hit_r;

  logic [erps_pkg::VAL_W-1:0]  edge_value;
  logic [erps_pkg::POS_W-1:0]  pos;
  logic [erps_pkg::LINE_W-1:0] line;

  logic                               new_line;
  logic signed [erps_pkg::GAP_W-1:0]  prev_eff;
  logic        [erps_pkg::FILL_W-1:0] fill_eff;
  logic                               is_edge;
  logic        [13:0]                 gap_wide;
  logic signed [erps_pkg::GAP_W-1:0]  gap;
  logic                               shift;

  logic signed [erps_pkg::GAP_W-1:0] s_a;
  logic signed [erps_pkg::GAP_W-1:0] s_b;
  logic        [13:0]                sum;
  logic        [13:0]                sum_adj;
  logic signed [erps_pkg::GAP_W-1:0] base;

  logic [erps_pkg::IDX_W-1:0]        nib_idx;
  logic [3:0]                        ratio;
  logic signed [erps_pkg::GAP_W-1:0] p_sel;
  logic                              ok;

  logic [erps_pkg::HIT_W-1:0] hit_fwd;
  logic [erps_pkg::HIT_W-1:0] hit_rev;

  assign edge_value = in_tdata[7:0];
  assign pos        = in_tdata[19:8];
  assign line       = in_tdata[31:20];

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= erps_pkg::THR_RST;
      lim_r <= erps_pkg::LIM_RST;
      pat_r <= erps_pkg::PAT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        erps_pkg::CFG_EDGE_THRESHOLD: thr_r <= cfg_wdata[erps_pkg::VAL_W-1:0];
        erps_pkg::CFG_ERROR_LIMIT:    lim_r <= cfg_wdata[erps_pkg::LIM_W-1:0];
        erps_pkg::CFG_RATIO_PATTERN:  pat_r <= cfg_wdata[erps_pkg::PAT_W-1:0];
        default: ;
      endcase
    end
  end

  // edge detect and window push
  assign new_line = (pos == '0);
  assign prev_eff = new_line ? -13'sd1 : prev_edge_r;
  assign fill_eff = new_line ? '0 : fill_r;
  assign is_edge  = ({1'b0, pos} < 13'(erps_pkg::LINE_LENGTH)) && (edge_value > thr_r);
  assign gap_wide = {2'b00, pos} - {prev_eff[12], prev_eff};
  assign gap      = gap_wide[12:0];
  assign shift    = (fill_eff >= 4'(erps_pkg::WIN_DEPTH));

  assign st.full = is_edge && (fill_eff >= 4'(erps_pkg::WIN_DEPTH - 1));
  assign st.ok   = ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      prev_edge_r <= -13'sd1;
    end else if (cmd.accept) begin
      if (is_edge) begin
        fill_r      <= shift ? 4'(erps_pkg::WIN_DEPTH) : fill_eff + 4'd1;
        prev_edge_r <= $signed({1'b0, pos});
      end else if (new_line) begin
        fill_r      <= '0;
        prev_edge_r <= -13'sd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_edge) begin
      for (int i = 0; i < erps_pkg::WIN_DEPTH - 1; i++) begin
        if (shift) begin
          gap_win_r[i]  <= gap_win_r[i+1];
          epos_win_r[i] <= epos_win_r[i+1];
        end else if (fill_eff == 4'(i)) begin
          gap_win_r[i]  <= gap;
          epos_win_r[i] <= pos;
        end
      end
      if (shift || fill_eff == 4'(erps_pkg::WIN_DEPTH - 1)) begin
        gap_win_r[erps_pkg::WIN_DEPTH-1]  <= gap;
        epos_win_r[erps_pkg::WIN_DEPTH-1] <= pos;
      end
      prev_old_r <= prev_eff;
      line_r     <= line;
    end
  end

  // base = (g6 + g7) / 2 forward, (g2 + g3) / 2 reversed, toward zero
  assign s_a     = cmd.rev ? gap_win_r[2] : gap_win_r[6];
  assign s_b     = cmd.rev ? gap_win_r[3] : gap_win_r[7];
  assign sum     = {s_a[12], s_a} + {s_b[12], s_b};
  assign sum_adj = sum + {13'b0, sum[13]};
  assign base    = sum_adj[13:1];

  assign nib_idx = cmd.rev ? ~cmd.idx : cmd.idx;
  assign ratio   = pat_r[{nib_idx, 2'b00} +: 4];
  assign p_sel   = gap_win_r[4'(cmd.idx) + 4'd1];

  erps_ratio u_ratio (
    .clk     (clk),
    .rst_n   (rst_n),
    .setup   (cmd.setup),
    .base_in (base),
    .lim     (lim_r),
    .issue   (cmd.issue),
    .ratio   (ratio),
    .gap     (p_sel),
    .ok      (ok)
  );

  // hit positions, wrapped to 15 bits
  assign hit_fwd = {{2{prev_old_r[12]}}, prev_old_r}
                 + {{2{gap_win_r[6][12]}}, gap_win_r[6]}
                 + {{2{gap_win_r[7][12]}}, gap_win_r[7]}
                 - 15'd2;
  assign hit_rev = {3'b000, epos_win_r[0]}
                 - {{2{gap_win_r[2][12]}}, gap_win_r[2]}
                 - {{2{gap_win_r[3][12]}}, gap_win_r[3]}
                 + 15'd2;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      side_r     <= cmd.rev;
      line_out_r <= line_r;
      hit_r      <= cmd.rev ? hit_rev : hit_fwd;
    end
  end

  assign out_tdata = {5'b00000, hit_r, line_out_r};
  assign out_tuser = side_r;

endmodule

/* hdl/erps_ctrl.sv */
// Controller: sequences window check passes and owns handshake state.
// Depends on erps_pkg.
module erps_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  erps_pkg::erps_stat_t st,
  output erps_pkg::erps_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_EVAL,
    ST_EMIT
  } state_t;

  state_t                     state_r;
  logic                       rev_r;
  logic [erps_pkg::IDX_W-1:0] idx_r;
  logic                       out_tvalid_r;

  logic accept;
  logic load_out;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign load_out  = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);

  assign cmd.accept   = accept;
  assign cmd.setup    = (state_r == ST_SETUP);
  assign cmd.issue    = (state_r == ST_RUN);
  assign cmd.idx      = idx_r;
  assign cmd.rev      = rev_r;
  assign cmd.load_out = load_out;

  assign out_tvalid = out_tvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rev_r        <= 1'b0;
      idx_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept && st.full) begin
            rev_r   <= 1'b0;
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          idx_r   <= '0;
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          idx_r <= idx_r + 3'd1;
          if (idx_r == 3'(erps_pkg::NUM_RATIO - 1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          if (st.ok) begin
            state_r <= ST_EMIT;
          end else if (!rev_r) begin
            rev_r   <= 1'b1;
            state_r <= ST_SETUP;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/edge_run_ratio_pattern_scanner_top.sv */
// Edge-run ratio pattern scanner, top level. An item that does not fill the
// ten-deep edge window leaves in_tready high. An edge that fills it starts
// the window check: each orientation (forward, then reversed if forward
// fails) steps through base set-up, eight ratios through the one shared
// two-stage multiply/compare unit, drain and evaluate; a passing check then
// loads a hit into the output register. Such an item holds in_tready low
// until the check ends, longer while an earlier result still waits in the
// output register. A waiting result does not stop the next item from being
// taken. Depends on erps_pkg, erps_ctrl, erps_dp and the defines header.
`include "edge_run_ratio_pattern_scanner_top_defines.svh"

module edge_run_ratio_pattern_scanner_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [erps_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [erps_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // edge_value [7:0], pos [19:8], line [31:20]
  input  logic [erps_pkg::IN_DW-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // line_index [11:0], hit_pos [26:12], zeros above
  output logic [erps_pkg::OUT_DW-1:0] out_tdata,
  // side [0]
  output logic                        out_tuser
);

  erps_pkg::erps_cmd_t  cmd;
  erps_pkg::erps_stat_t st;
  logic                 in_acc;

  assign in_acc = in_tvalid && in_tready;

  erps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  erps_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .st        (st),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  `ERPS_ASSERT_NEXT(a_fill_starts_check, in_acc && st.full, !in_tready, "check not started")
  `ERPS_ASSERT_NEXT(a_plain_item_ready, in_acc && !st.full, in_tready, "plain item blocked")
  `ERPS_ASSERT_SAME(a_load_returns_idle, $rose(out_tvalid), in_tready, "result not from idle")

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench for edge_run_ratio_pattern_scanner_top: pixel streams with ratio-shaped edge runs,
// a border-hit predictor in a small class, and random idling on both stream sides.
// Depends on erps_pkg and the scanner RTL.
module tb;
  import erps_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam logic SIDE_FWD = 1'b0;
  localparam logic SIDE_REV = 1'b1;

  typedef struct packed {
    logic              side;
    logic [LINE_W-1:0] line_index;
    logic [HIT_W-1:0]  hit_pos;
  } hit_t;

  class border_hit_tracker;
    logic [VAL_W-1:0]        thr;
    logic [LIM_W-1:0]        lim;
    logic [PAT_W-1:0]        pat;
    logic signed [GAP_W-1:0] gaps[WIN_DEPTH];
    logic [POS_W-1:0]        edges[WIN_DEPTH];
    logic signed [GAP_W-1:0] last_edge;
    int unsigned             fill;
    hit_t                    hits_due[$];
    int                      fails;
    int                      shown;

    function new();
      thr = THR_RST;
      lim = LIM_RST;
      pat = PAT_RST;
      fails = 0;
      shown = 0;
      clear_line();
    endfunction

    function void clear_line();
      for (int i = 0; i < WIN_DEPTH; i++) begin
        gaps[i] = '0;
        edges[i] = '0;
      end
      fill = 0;
      last_edge = -13'sd1;
    endfunction

    function int ratio_of(int k);
      return int'(pat[4*(k-1) +: 4]);
    endfunction

    function bit ratio_fits(longint a, longint p, longint base);
      longint d;
      longint b_abs;
      if (a == 0 || base == 0) return 1'b0;
      d = a * base - p;
      if (d < 0) d = -d;
      b_abs = (base < 0) ? -base : base;
      return d * 100 < (longint'(lim) + 1) * a * b_abs;
    endfunction

    function bit pattern_fits(bit rev);
      longint base;
      longint a;
      if (rev) base = (longint'(gaps[2]) + longint'(gaps[3])) / 2;
      else base = (longint'(gaps[6]) + longint'(gaps[7])) / 2;
      for (int k = 1; k <= NUM_RATIO; k++) begin
        a = longint'(rev ? ratio_of(9 - k) : ratio_of(k));
        if (!ratio_fits(a, longint'(gaps[k]), base)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_fail(string msg);
      fails++;
      if (shown < 10) begin
        $display("%s", msg);
        shown++;
      end
    endfunction

    function void queue_hit(hit_t h);
      hits_due.insert(hits_due.size(), h);
    endfunction

    // called once per accepted pixel
    function void take_pixel(logic [VAL_W-1:0] val, logic [POS_W-1:0] pos,
                             logic [LINE_W-1:0] ln);
      int     gap;
      longint spot;
      hit_t   h;
      if (pos == 0) clear_line();
      if (val <= thr) return;
      gap = int'(pos) - int'(last_edge);
      if (gap > 4095) gap -= 8192;
      if (fill >= WIN_DEPTH) begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          gaps[i] = gaps[i+1];
          edges[i] = edges[i+1];
        end
        fill = WIN_DEPTH - 1;
      end
      gaps[fill] = gap[GAP_W-1:0];
      edges[fill] = pos;
      fill++;
      if (fill == WIN_DEPTH) begin
        if (pattern_fits(1'b0)) begin
          spot = longint'(last_edge) + longint'(gaps[6]) + longint'(gaps[7]) - 2;
          h.side = SIDE_FWD;
          h.line_index = ln;
          h.hit_pos = spot[HIT_W-1:0];
          queue_hit(h);
        end else if (pattern_fits(1'b1)) begin
          spot = longint'(edges[0]) - longint'(gaps[2]) - longint'(gaps[3]) + 2;
          h.side = SIDE_REV;
          h.line_index = ln;
          h.hit_pos = spot[HIT_W-1:0];
          queue_hit(h);
        end
      end
      last_edge = $signed({1'b0, pos});
    endfunction

    function void match_hit(hit_t got);
      hit_t want;
      if (hits_due.size() == 0) begin
        note_fail($sformatf("unexpected hit: side=%0d line=%0d pos=%0d",
                            got.side, got.line_index, $signed(got.hit_pos)));
        return;
      end
      want = hits_due.pop_front();
      if (got.side !== want.side || got.line_index !== want.line_index ||
          got.hit_pos !== want.hit_pos)
        note_fail($sformatf({"hit mismatch: expected side=%0d line=%0d pos=%0d,",
                             " got side=%0d line=%0d pos=%0d"},
                            want.side, want.line_index, $signed(want.hit_pos),
                            got.side, got.line_index, $signed(got.hit_pos)));
    endfunction

    function int pending();
      return hits_due.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic                out_tuser;

  border_hit_tracker hits = new();
  int                in_idle_pct = 16;
  int                out_idle_pct = 58;
  int                sent = 0;
  bit                fire;
  hit_t              seen;

  edge_run_ratio_pattern_scanner_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: sample mid-cycle, check at the edge that takes the item
  initial begin
    forever begin
      @(negedge clk);
      fire = rst_n && out_tvalid && out_tready;
      seen.side = out_tuser;
      seen.line_index = out_tdata[LINE_W-1:0];
      seen.hit_pos = out_tdata[LINE_W +: HIT_W];
      @(posedge clk);
      if (fire) hits.match_hit(seen);
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic feed_pixel(logic [VAL_W-1:0] val, logic [POS_W-1:0] pos,
                            logic [LINE_W-1:0] ln);
    bit ok;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ln, pos, val};
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    hits.take_pixel(val, pos, ln);
    sent++;
  endtask

  function automatic logic [VAL_W-1:0] edge_px();
    if (hits.thr == 8'd255) return 8'd255;
    return VAL_W'($urandom_range(255, int'(hits.thr) + 1));
  endfunction

  function automatic logic [VAL_W-1:0] quiet_px();
    return VAL_W'($urandom_range(int'(hits.thr), 0));
  endfunction

  function automatic logic [PAT_W-1:0] friendly_pattern(bit with_zero);
    logic [PAT_W-1:0] p;
    for (int k = 1; k <= NUM_RATIO; k++) begin
      p[4*(k-1) +: 4] = (k == 6 || k == 7) ? 4'd1 : 4'($urandom_range(15, 1));
      if ($urandom_range(29) == 0) p[4*(k-1) +: 4] = 4'd0;
    end
    if (with_zero) p[4*$urandom_range(7) +: 4] = 4'd0;
    return p;
  endfunction

  task automatic set_regs(logic [VAL_W-1:0] thr, logic [LIM_W-1:0] lim,
                          logic [PAT_W-1:0] pat);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_EDGE_THRESHOLD;
    cfg_wdata <= CFG_DW'(thr);
    @(posedge clk);
    cfg_addr <= CFG_ERROR_LIMIT;
    cfg_wdata <= CFG_DW'(lim);
    @(posedge clk);
    cfg_addr <= CFG_RATIO_PATTERN;
    cfg_wdata <= pat;
    @(posedge clk);
    cfg_we <= 1'b0;
    hits.thr = thr;
    hits.lim = lim;
    hits.pat = pat;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (hits.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // optional quiet pixel inside the gap, then the next edge
  task automatic edge_after(inout logic [POS_W-1:0] p, input int g,
                            input logic [LINE_W-1:0] ln);
    if (g > 1 && $urandom_range(4) == 0)
      feed_pixel(quiet_px(), POS_W'(int'(p) + $urandom_range(g - 1, 1)), ln);
    p = POS_W'(int'(p) + g);
    feed_pixel(edge_px(), p, ln);
  endtask

  // a scan line whose edge gaps follow the current ratios, forward or reversed, unless spoiled
  task automatic lay_pattern_line(bit rev, bit spoil);
    logic [LINE_W-1:0] ln;
    logic [POS_W-1:0]  p;
    int unit[1:8];
    int total, u, umax, g, pct, jit, bad, extra;
    bit zero_base;
    ln = LINE_W'($urandom);
    total = 0;
    for (int k = 1; k <= NUM_RATIO; k++) begin
      unit[k] = hits.ratio_of(rev ? 9 - k : k);
      if (unit[k] == 0) unit[k] = 2;
      total += unit[k];
    end
    umax = 3600 / total;
    if (umax < 1) umax = 1;
    if (umax > 30) umax = 30;
    u = $urandom_range(umax, 1);
    bad = spoil ? $urandom_range(8, 1) : 0;
    zero_base = spoil && ($urandom_range(3) == 0);
    if ($urandom_range(1)) begin
      p = '0;
      feed_pixel(edge_px(), p, ln);
    end else begin
      feed_pixel(quiet_px(), '0, ln);
      p = POS_W'($urandom_range(250, 1));
      feed_pixel(edge_px(), p, ln);
    end
    for (int k = 1; k <= NUM_RATIO; k++) begin
      g = unit[k] * u;
      pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(25);
      jit = g * pct / 100;
      g = $urandom_range(1) ? g + jit : g - jit;
      if (g < 1) g = 1;
      if (k == bad) begin
        case ($urandom_range(2))
          0: g = $urandom_range(300, 1);
          1: g = 0;
          default: g = -$urandom_range(20, 1);
        endcase
      end
      if (zero_base && k == (rev ? 2 : 6)) g = 0;
      if (zero_base && k == (rev ? 3 : 7)) g = 1;
      edge_after(p, g, ln);
    end
    extra = 1 + $urandom_range(2);
    for (int k = 0; k < extra; k++) edge_after(p, $urandom_range(3 * u, 1), ln);
  endtask

  task automatic noise_burst();
    int n;
    n = $urandom_range(8, 1);
    for (int i = 0; i < n; i++)
      feed_pixel(VAL_W'($urandom), ($urandom_range(9) == 0) ? '0 : POS_W'($urandom),
                 LINE_W'($urandom));
  endtask

  task automatic random_pixels(int quota);
    int start;
    int r;
    start = sent;
    while (sent - start < quota) begin
      r = $urandom_range(99);
      if (r < 65) lay_pattern_line($urandom_range(2) == 0, 1'b0);
      else if (r < 80) lay_pattern_line($urandom_range(2) == 0, 1'b1);
      else noise_burst();
    end
  endtask

  task automatic directed_pixels();
    int fwd_pos[10] = '{0, 24, 32, 44, 52, 60, 64, 68, 80, 85};
    int rev_pos[10] = '{0, 15, 20, 25, 35, 45, 60, 70, 100, 107};
    feed_pixel(8'd0, 12'd0, 12'd0);
    feed_pixel(8'd255, 12'd4095, 12'd4095);   // first edge at line end: gap wraps
    feed_pixel(8'd200, 12'd4094, 12'h555);    // at threshold, not an edge
    feed_pixel(8'd201, 12'd4093, 12'hAAA);    // backward gap
    feed_pixel(8'd255, 12'd1, 12'd0);
    feed_pixel(8'h80, 12'h555, 12'hFFF);
    foreach (fwd_pos[i]) feed_pixel(edge_px(), POS_W'(fwd_pos[i]), 12'hFFF);
    foreach (rev_pos[i]) feed_pixel(edge_px(), POS_W'(rev_pos[i]), 12'h3C5);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct = 16;
    out_idle_pct = 58;
    directed_pixels();
    random_pixels(80);
    settle();
    set_regs(8'd0, 7'd100, friendly_pattern(1'b0));
    random_pixels(100);
    settle();
    set_regs(8'd255, 7'd0, 32'h0);
    random_pixels(30);
    settle();

    in_idle_pct = 58;
    out_idle_pct = 16;
    set_regs(VAL_W'($urandom_range(220, 20)), 7'd0, friendly_pattern(1'b0));
    random_pixels(100);
    settle();
    set_regs(VAL_W'($urandom_range(220, 20)), 7'd100, friendly_pattern(1'b1));
    random_pixels(80);
    settle();

    in_idle_pct = 0;
    out_idle_pct = 0;
    set_regs(VAL_W'($urandom_range(220, 20)), LIM_W'($urandom_range(100)), 32'hFFFF_FFFF);
    random_pixels(60);
    settle();
    set_regs(THR_RST, LIM_RST, PAT_RST);
    random_pixels(100);
    settle();
    set_regs(VAL_W'($urandom_range(220, 20)), LIM_W'($urandom_range(60, 10)),
             friendly_pattern(1'b0));
    random_pixels(90);

    settle();
    if (hits.pending() != 0)
      hits.note_fail($sformatf("%0d hits never arrived", hits.pending()));
    if (hits.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
